// ===== rtl/core/gwm_pkg.sv =====
// ----------------------------------------------------------------------------
// gwm_pkg: shared types and constants for the glob rule path matcher
// Rule table geometry, wildcard codes, command codes and the control
// bundles that run between the top level, the rule rows and their cells.
// ----------------------------------------------------------------------------
`default_nettype none

package gwm_pkg;

  // Rule table geometry
  localparam int unsigned RuleSlots  = 8;
  localparam int unsigned PatternLen = 32;
  localparam int unsigned CharBits   = 16;

  localparam int unsigned SlotW = (RuleSlots > 1) ? $clog2(RuleSlots) : 1;
  localparam int unsigned PosW  = (PatternLen > 1) ? $clog2(PatternLen) : 1;
  localparam int unsigned LenW  = $clog2(PatternLen + 1);
  localparam int unsigned RowW  = PatternLen + 1;

  // Wire widths of the beat fields
  localparam int unsigned CmdW      = 2;
  localparam int unsigned FSlotW    = 3;
  localparam int unsigned FPosW     = 5;
  localparam int unsigned FCharW    = 16;
  localparam int unsigned FLenW     = 6;
  localparam int unsigned InDataW   = 32;
  localparam int unsigned OutDataW  = 8;

  // Wildcard codes
  localparam logic [CharBits-1:0] StarChar = CharBits'(8'h2A);
  localparam logic [CharBits-1:0] AnyChar  = CharBits'(8'h3F);

  // Input beat kinds
  typedef enum logic [CmdW-1:0] {
    CMD_WRITE_CHAR = 2'd0,
    CMD_SET_HEADER = 2'd1,
    CMD_PATH_CHAR  = 2'd2,
    CMD_END_PATH   = 2'd3
  } cmd_e;

  // Per-row control from the command decoder
  typedef struct packed {
    logic wr_char;   // write one pattern char of this row
    logic set_hdr;   // load header of this row and re-arm it
    logic advance;   // step the row by one path char
    logic arm_all;   // end of path: re-arm
  } row_ctrl_t;

  // Status of one position cell toward the row
  typedef struct packed {
    logic star;      // live '*' inside the rule length
    logic stay;      // '*' keeps its own position alive
    logic hand;      // char matched: pass to the next position
  } cell_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/gwm_cell.sv =====
// ----------------------------------------------------------------------------
// gwm_cell: one pattern position of a rule row
// Holds one pattern char, compares it against the path char and hands the
// live state on to the next position or keeps it on a star.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_cell (
  input  wire logic                         clk_i,
  input  wire logic                         wr_en_i,
  input  wire logic [gwm_pkg::CharBits-1:0] wr_char_i,
  input  wire logic [gwm_pkg::CharBits-1:0] path_char_i,
  input  wire logic                         in_range_i,
  input  wire logic                         closed_i,
  output gwm_pkg::cell_out_t                cell_o
);

  logic [gwm_pkg::CharBits-1:0] char_q;
  logic                         star_q;
  logic                         any_q;
  logic                         hit;

  // Store pattern char with its wildcard flags
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      char_q <= wr_char_i;
      star_q <= (wr_char_i == gwm_pkg::StarChar);
      any_q  <= (wr_char_i == gwm_pkg::AnyChar);
    end
  end

  // Match one path char
  assign hit = any_q || (char_q == path_char_i);

  always_comb begin
    cell_o.star = star_q & in_range_i;
    cell_o.stay = closed_i & in_range_i & star_q;
    cell_o.hand = closed_i & in_range_i & ~star_q & hit;
  end

endmodule

`default_nettype wire

// ===== rtl/core/gwm_row.sv =====
// ----------------------------------------------------------------------------
// gwm_row: one rule of the table as a chain of position cells
// Keeps the rule header and the live-prefix bits, applies the star closure
// with one carry chain and reports an include or exclude hit at end of path.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_row (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire gwm_pkg::row_ctrl_t           ctrl_i,
  input  wire logic [gwm_pkg::FPosW-1:0]    char_pos_i,
  input  wire logic [gwm_pkg::CharBits-1:0] char_value_i,
  input  wire logic [gwm_pkg::FLenW-1:0]    rule_length_i,
  input  wire logic                         rule_negated_i,
  input  wire logic                         rule_enabled_i,
  output logic                              inc_hit_o,
  output logic                              exc_hit_o
);

  localparam int unsigned N = gwm_pkg::PatternLen;
  localparam int unsigned W = gwm_pkg::RowW;

  logic [gwm_pkg::LenW-1:0] len_q, len_d;
  logic                     neg_q;
  logic                     en_q;
  logic [W-1:0]             alive_q, alive_d;
  logic [W-1:0]             star_v;
  logic [W-1:0]             gen_v;
  logic [W-1:0]             sum_v;
  logic [W-1:0]             closed;
  logic [N-1:0]             stay_v;
  logic [N-1:0]             hand_v;
  logic                     row_hit;
  logic                     arm;

  gwm_pkg::cell_out_t       cell_out [N];

  // Saturate the rule length at the pattern depth
  always_comb begin
    if (rule_length_i > gwm_pkg::FLenW'(N)) begin
      len_d = gwm_pkg::LenW'(N);
    end else begin
      len_d = gwm_pkg::LenW'(rule_length_i);
    end
  end

  // Hold the rule header
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      neg_q <= 1'b0;
      en_q  <= 1'b0;
    end else if (ctrl_i.set_hdr) begin
      len_q <= len_d;
      neg_q <= rule_negated_i;
      en_q  <= rule_enabled_i;
    end
  end

  // Row of position cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic wr_en;
    logic in_range;

    assign wr_en    = ctrl_i.wr_char && (char_pos_i == gwm_pkg::FPosW'(i));
    assign in_range = gwm_pkg::LenW'(i) < len_q;

    gwm_cell u_cell (
      .clk_i       (clk_i),
      .wr_en_i     (wr_en),
      .wr_char_i   (char_value_i[gwm_pkg::CharBits-1:0]),
      .path_char_i (char_value_i[gwm_pkg::CharBits-1:0]),
      .in_range_i  (in_range),
      .closed_i    (closed[i]),
      .cell_o      (cell_out[i])
    );

    assign star_v[i] = cell_out[i].star;
    assign stay_v[i] = cell_out[i].stay;
    assign hand_v[i] = cell_out[i].hand;
  end

  assign star_v[N] = 1'b0;

  // Star closure as a carry chain: runs of stars propagate a live bit
  assign gen_v  = star_v & alive_q;
  assign sum_v  = star_v + gen_v;
  assign closed = alive_q | (sum_v ^ star_v ^ gen_v);

  // Whole-rule hit at the end position
  assign row_hit   = closed[len_q];
  assign inc_hit_o = en_q & ~neg_q & row_hit;
  assign exc_hit_o = en_q & neg_q & row_hit;

  // Next live-prefix bits: re-arm, or take hand-offs from the left neighbor
  assign arm = ctrl_i.set_hdr | ctrl_i.arm_all;

  always_comb begin
    alive_d = alive_q;
    if (arm) begin
      alive_d    = '0;
      alive_d[0] = 1'b1;
    end else if (ctrl_i.advance) begin
      alive_d[0] = stay_v[0];
      for (int unsigned i = 1; i < N; i++) begin
        alive_d[i] = stay_v[i] | hand_v[i-1];
      end
      alive_d[N] = hand_v[N-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q <= W'(1);
    end else begin
      alive_q <= alive_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/glob_rule_path_matcher.sv =====
// ----------------------------------------------------------------------------
// glob_rule_path_matcher: include/exclude wildcard rule matcher for paths
// Streams rule text and path chars in, runs every rule as a row of
// position cells and returns one verdict beat per end of path.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Beat contents
//  s_axis   | in        | tuser: cmd; tdata: rule fields or path char
//  m_axis   | out       | tdata: matched, include_hit, exclude_hit
//  cfg      | in        | default_all, one bit, written when cfg_we_i is high
//
//  One input beat per cycle while s_axis_tready is high; every rule row steps in parallel on a path char.
//  An end of path yields its verdict beat in the next cycle from the output
//  register; that register frees in the cycle m_axis_tready takes it.
//  s_axis_tready drops only while a verdict waits and m_axis_tready is low.
//  Reset clears all headers, arms every row and sets default_all.
// ----------------------------------------------------------------------------
`default_nettype none

module glob_rule_path_matcher (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,

  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [2:0] rule_slot, [7:3] char_pos, [23:8] char_value, [29:24] rule_length,
  // [30] rule_negated, [31] rule_enabled
  input  wire logic [gwm_pkg::InDataW-1:0]   s_axis_tdata,
  // [1:0] cmd
  input  wire logic [gwm_pkg::CmdW-1:0]      s_axis_tuser,

  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [0] matched, [1] include_hit, [2] exclude_hit, [7:3] zero
  output logic [gwm_pkg::OutDataW-1:0]       m_axis_tdata,

  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_wdata_i
);

  localparam int unsigned S = gwm_pkg::RuleSlots;

  logic                            accept;
  gwm_pkg::cmd_e                   cmd;
  logic [gwm_pkg::FSlotW-1:0]      rule_slot;
  logic [gwm_pkg::FPosW-1:0]       char_pos;
  logic [gwm_pkg::FCharW-1:0]      char_value;
  logic [gwm_pkg::FLenW-1:0]       rule_length;
  logic                            rule_negated;
  logic                            rule_enabled;

  logic                            is_wr, is_hdr, is_path, is_end;
  logic [S-1:0]                    inc_v, exc_v;
  logic                            inc_any, exc_any, verdict;

  logic                            default_all_q;
  logic                            out_valid_q, out_valid_d;
  logic [2:0]                      out_bits_q;

  // Unpack the input beat
  assign cmd          = gwm_pkg::cmd_e'(s_axis_tuser);
  assign rule_slot    = s_axis_tdata[2:0];
  assign char_pos     = s_axis_tdata[7:3];
  assign char_value   = s_axis_tdata[23:8];
  assign rule_length  = s_axis_tdata[29:24];
  assign rule_negated = s_axis_tdata[30];
  assign rule_enabled = s_axis_tdata[31];

  // Take a beat unless a verdict is stuck in the output register
  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign accept        = s_axis_tvalid & s_axis_tready;

  // Decode the command
  always_comb begin
    is_wr   = 1'b0;
    is_hdr  = 1'b0;
    is_path = 1'b0;
    is_end  = 1'b0;
    unique case (cmd)
      gwm_pkg::CMD_WRITE_CHAR: is_wr   = accept;
      gwm_pkg::CMD_SET_HEADER: is_hdr  = accept;
      gwm_pkg::CMD_PATH_CHAR:  is_path = accept;
      gwm_pkg::CMD_END_PATH:   is_end  = accept;
      default: ;
    endcase
  end

  // Rule rows
  for (genvar s = 0; s < S; s++) begin : g_row
    gwm_pkg::row_ctrl_t ctrl;
    logic               sel;

    assign sel          = (rule_slot == gwm_pkg::FSlotW'(s));
    assign ctrl.wr_char = is_wr & sel;
    assign ctrl.set_hdr = is_hdr & sel;
    assign ctrl.advance = is_path;
    assign ctrl.arm_all = is_end;

    gwm_row u_row (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (ctrl),
      .char_pos_i     (char_pos),
      .char_value_i   (char_value[gwm_pkg::CharBits-1:0]),
      .rule_length_i  (rule_length),
      .rule_negated_i (rule_negated),
      .rule_enabled_i (rule_enabled),
      .inc_hit_o      (inc_v[s]),
      .exc_hit_o      (exc_v[s])
    );
  end

  // Combine hits under the ordering mode
  assign inc_any = |inc_v;
  assign exc_any = |exc_v;
  assign verdict = default_all_q ? (inc_any | ~exc_any) : (inc_any & ~exc_any);

  // Hold the ordering mode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_all_q <= 1'b1;
    end else if (cfg_we_i) begin
      default_all_q <= cfg_wdata_i;
    end
  end

  // Output register: load on end of path, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (is_end) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_end) begin
      out_bits_q <= {exc_any, inc_any, verdict};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(gwm_pkg::OutDataW - 3){1'b0}}, out_bits_q};

endmodule

`default_nettype wire

// ===== verif/glob_rule_path_matcher_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glob_rule_path_matcher_test: self-checking bench for the glob rule matcher
// Loads include/exclude wildcard rules and streams paths through the beat
// interface. Each end of path is judged by a behavioral row tracker kept
// here, and the verdict beats are compared in order. Runs a directed opening
// and then randomized phases under both ordering modes and several
// sender and receiver stall mixes.
// ----------------------------------------------------------------------------

module glob_rule_path_matcher_test;

  // One input beat as the generator sees it
  typedef struct {
    gwm_pkg::cmd_e cmd;
    logic [2:0]    slot;
    logic [4:0]    pos;
    logic [15:0]   ch;
    logic [5:0]    len;
    logic          neg;
    logic          en;
    bit            hold;   // wait until every verdict is back before sending
  } beat_t;

  typedef struct packed {
    logic matched;
    logic include_hit;
    logic exclude_hit;
  } verdict_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  wire                          s_axis_tready;
  logic [gwm_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic [gwm_pkg::CmdW-1:0]     s_axis_tuser = '0;
  wire                          m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  wire [gwm_pkg::OutDataW-1:0]  m_axis_tdata;
  logic                         cfg_we_i = 1'b0;
  logic                         cfg_wdata_i = 1'b0;

  glob_rule_path_matcher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Bench-side rule table and row state, updated on every accepted beat
  logic [gwm_pkg::CharBits-1:0] rule_char [gwm_pkg::RuleSlots][gwm_pkg::PatternLen];
  int                           rule_len  [gwm_pkg::RuleSlots];
  bit                           rule_excl [gwm_pkg::RuleSlots];
  bit                           rule_on   [gwm_pkg::RuleSlots];
  logic [gwm_pkg::RowW-1:0]     live_row  [gwm_pkg::RuleSlots];
  bit                           default_all_q = 1'b1;

  // Generator view of the table, kept in queue order
  logic [gwm_pkg::CharBits-1:0] gen_char [gwm_pkg::RuleSlots][gwm_pkg::PatternLen];
  int                           gen_len  [gwm_pkg::RuleSlots];

  beat_t    pend_beats[$];
  verdict_t verdict_q[$];
  int       in_issued = 0;
  int       in_taken = 0;
  int       err_count = 0;
  int       paths_judged = 0;
  int       inc_seen = 0;
  int       exc_seen = 0;
  int       mode_writes = 0;
  int       snd_idle_pct = 0;
  int       rcv_stall_pct = 0;
  bit       hold_next = 1'b0;

  task automatic flag_error(string msg);
    err_count++;
    if (err_count <= 10) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
  endtask

  // Let every live '*' position carry its state to the following one
  function automatic logic [gwm_pkg::RowW-1:0] close_stars(int s,
                                                            logic [gwm_pkg::RowW-1:0] row);
    for (int i = 0; i < rule_len[s]; i++) begin
      if (row[i] && rule_char[s][i] == gwm_pkg::StarChar) row[i+1] = 1'b1;
    end
    return row;
  endfunction

  function automatic void step_rows(logic [gwm_pkg::CharBits-1:0] ch);
    logic [gwm_pkg::RowW-1:0] cur;
    logic [gwm_pkg::RowW-1:0] nxt;
    for (int s = 0; s < gwm_pkg::RuleSlots; s++) begin
      cur = close_stars(s, live_row[s]);
      nxt = '0;
      for (int i = 0; i < rule_len[s]; i++) begin
        if (cur[i]) begin
          if (rule_char[s][i] == gwm_pkg::StarChar) nxt[i] = 1'b1;
          else if (rule_char[s][i] == ch || rule_char[s][i] == gwm_pkg::AnyChar)
            nxt[i+1] = 1'b1;
        end
      end
      live_row[s] = nxt;
    end
  endfunction

  // Judge the path against every enabled rule, queue the verdict, re-arm rows
  function automatic void judge_path();
    logic [gwm_pkg::RowW-1:0] cur;
    verdict_t v;
    v = '0;
    for (int s = 0; s < gwm_pkg::RuleSlots; s++) begin
      cur = close_stars(s, live_row[s]);
      if (rule_on[s] && cur[rule_len[s]]) begin
        if (rule_excl[s]) v.exclude_hit = 1'b1;
        else v.include_hit = 1'b1;
      end
      live_row[s] = gwm_pkg::RowW'(1);
    end
    v.matched = default_all_q ? (v.include_hit || !v.exclude_hit)
                              : (v.include_hit && !v.exclude_hit);
    paths_judged++;
    if (v.include_hit) inc_seen++;
    if (v.exclude_hit) exc_seen++;
    verdict_q = {verdict_q, v};
  endfunction

  function automatic void apply_beat(gwm_pkg::cmd_e cmd, int slot, int pos, logic [15:0] ch,
                                     int len, bit neg, bit en);
    case (cmd)
      gwm_pkg::CMD_WRITE_CHAR: begin
        if (slot < gwm_pkg::RuleSlots && pos < gwm_pkg::PatternLen)
          rule_char[slot][pos] = ch[gwm_pkg::CharBits-1:0];
      end
      gwm_pkg::CMD_SET_HEADER: begin
        if (slot < gwm_pkg::RuleSlots) begin
          rule_len[slot]  = (len > gwm_pkg::PatternLen) ? gwm_pkg::PatternLen : len;
          rule_excl[slot] = neg;
          rule_on[slot]   = en;
          live_row[slot]  = gwm_pkg::RowW'(1);
        end
      end
      gwm_pkg::CMD_PATH_CHAR: step_rows(ch[gwm_pkg::CharBits-1:0]);
      default: judge_path();
    endcase
  endfunction

  // Queue one beat; fields the command does not use carry random bits
  task automatic push_beat(gwm_pkg::cmd_e cmd, int slot, int pos, logic [15:0] ch,
                           int len, bit neg, bit en);
    beat_t b;
    b.cmd  = cmd;
    b.slot = 3'($urandom);
    b.pos  = 5'($urandom);
    b.ch   = 16'($urandom);
    b.len  = 6'($urandom);
    b.neg  = 1'($urandom);
    b.en   = 1'($urandom);
    b.hold = hold_next || ($urandom_range(0, 49) == 0);
    hold_next = 1'b0;
    case (cmd)
      gwm_pkg::CMD_WRITE_CHAR: begin
        b.slot = 3'(slot);
        b.pos  = 5'(pos);
        b.ch   = ch;
        gen_char[slot][pos] = ch;
      end
      gwm_pkg::CMD_SET_HEADER: begin
        b.slot = 3'(slot);
        b.len  = 6'(len);
        b.neg  = neg;
        b.en   = en;
        gen_len[slot] = (len > gwm_pkg::PatternLen) ? gwm_pkg::PatternLen : len;
      end
      gwm_pkg::CMD_PATH_CHAR: b.ch = ch;
      default: ;
    endcase
    pend_beats = {pend_beats, b};
  endtask

  function automatic logic [15:0] pick_path_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return 16'h0061;
      3, 4:    return 16'h0062;
      5, 6:    return 16'h002F;
      7:       return gwm_pkg::StarChar;
      8:       return gwm_pkg::AnyChar;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_rule_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return gwm_pkg::StarChar;
      3:       return gwm_pkg::AnyChar;
      4, 5:    return 16'h0061;
      6:       return 16'h0062;
      7, 8:    return 16'h002F;
      default: return 16'($urandom);
    endcase
  endfunction

  // Write every char the header will cover, then the header itself
  task automatic program_rule(int slot, int len);
    int n;
    n = (len > gwm_pkg::PatternLen) ? gwm_pkg::PatternLen : len;
    for (int i = 0; i < n; i++) begin
      push_beat(gwm_pkg::CMD_WRITE_CHAR, slot, i, pick_rule_char(), 0, 0, 0);
    end
    push_beat(gwm_pkg::CMD_SET_HEADER, slot, 0, 0, len, $urandom_range(0, 2) == 0,
              $urandom_range(0, 6) != 0);
  endtask

  // Rule edits that land in the middle of a path
  task automatic mid_path_edit();
    int s;
    s = $urandom_range(0, gwm_pkg::RuleSlots - 1);
    if ($urandom_range(0, 1)) begin
      push_beat(gwm_pkg::CMD_WRITE_CHAR, s, $urandom_range(0, gwm_pkg::PatternLen - 1),
                pick_rule_char(), 0, 0, 0);
    end else begin
      push_beat(gwm_pkg::CMD_SET_HEADER, s, 0, 0, gen_len[s], $urandom_range(0, 2) == 0,
                $urandom_range(0, 6) != 0);
    end
  endtask

  // Expand a rule into a path that fits it, optionally spoiled
  task automatic send_path(int slot, bit garble);
    logic [15:0] chars[$];
    logic [15:0] c;
    for (int i = 0; i < gen_len[slot]; i++) begin
      c = gen_char[slot][i];
      if (c == gwm_pkg::StarChar) begin
        repeat ($urandom_range(0, 2)) chars = {chars, pick_path_char()};
      end else if (c == gwm_pkg::AnyChar) begin
        chars = {chars, pick_path_char()};
      end else begin
        chars = {chars, c};
      end
    end
    if (garble && chars.size() > 0) chars[$urandom_range(0, chars.size() - 1)] = pick_path_char();
    if (garble && $urandom_range(0, 1)) chars = {chars, pick_path_char()};
    if (chars.size() > 40) chars = chars[0:39];
    foreach (chars[i]) begin
      if ($urandom_range(0, 19) == 0) mid_path_edit();
      push_beat(gwm_pkg::CMD_PATH_CHAR, 0, 0, chars[i], 0, 0, 0);
    end
    push_beat(gwm_pkg::CMD_END_PATH, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pend_beats.size() != 0 || in_taken != in_issued || verdict_q.size() != 0);
    // end of path lands in the output register in the cycle after it is taken
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_mode(bit v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    default_all_q = v;
    mode_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Driver: present the next queued beat once the current one is taken
  always @(negedge clk_i) begin : drive_in
    beat_t b;
    if (rst_ni && (!s_axis_tvalid || in_taken == in_issued)) begin
      if (pend_beats.size() != 0 && !(pend_beats[0].hold && verdict_q.size() != 0) &&
          $urandom_range(0, 99) >= snd_idle_pct) begin
        b = pend_beats.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b.en, b.neg, b.len, b.ch, b.pos, b.slot};
        s_axis_tuser  <= b.cmd;
        in_issued++;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
  end

  // Monitor: check verdict beats first, then fold the accepted input beat in
  always @(posedge clk_i) begin : watch
    verdict_t got;
    verdict_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.matched     = m_axis_tdata[0];
        got.include_hit = m_axis_tdata[1];
        got.exclude_hit = m_axis_tdata[2];
        if (verdict_q.size() == 0) begin
          flag_error($sformatf("verdict beat with none pending: m/i/e=%b/%b/%b",
                               got.matched, got.include_hit, got.exclude_hit));
        end else begin
          want = verdict_q.pop_front();
          if (got.matched !== want.matched || got.include_hit !== want.include_hit ||
              got.exclude_hit !== want.exclude_hit) begin
            flag_error($sformatf("verdict m/i/e exp %b/%b/%b got %b/%b/%b",
                                 want.matched, want.include_hit, want.exclude_hit,
                                 got.matched, got.include_hit, got.exclude_hit));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        apply_beat(gwm_pkg::cmd_e'(s_axis_tuser), int'(s_axis_tdata[2:0]),
                   int'(s_axis_tdata[7:3]), s_axis_tdata[23:8],
                   int'(s_axis_tdata[29:24]), s_axis_tdata[30], s_axis_tdata[31]);
        in_taken++;
      end
    end
  end

  initial begin
    #2ms;
    $display("timeout waiting for the matcher to drain");
    $display("glob_rule_path_matcher verification failed");
    $finish;
  end

  initial begin : stimulus
    int snd_mix [4];
    int rcv_stall_mix [4];
    int r;
    snd_mix       = '{0, 71, 0, 15};
    rcv_stall_mix = '{0, 0, 71, 15};
    for (int s = 0; s < gwm_pkg::RuleSlots; s++) begin
      rule_len[s]  = 0;
      rule_excl[s] = 1'b0;
      rule_on[s]   = 1'b0;
      live_row[s]  = gwm_pkg::RowW'(1);
      gen_len[s]   = 0;
      for (int i = 0; i < gwm_pkg::PatternLen; i++) begin
        rule_char[s][i] = '0;
        gen_char[s][i]  = '0;
      end
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty path on a fresh table
    push_beat(gwm_pkg::CMD_END_PATH, 0, 0, 0, 0, 0, 0);
    // include "*" in slot 0, exclude "a?" in slot 1, then path "ab"
    push_beat(gwm_pkg::CMD_WRITE_CHAR, 0, 0, gwm_pkg::StarChar, 0, 0, 0);
    push_beat(gwm_pkg::CMD_SET_HEADER, 0, 0, 0, 1, 0, 1);
    push_beat(gwm_pkg::CMD_WRITE_CHAR, 1, 0, 16'h0061, 0, 0, 0);
    push_beat(gwm_pkg::CMD_WRITE_CHAR, 1, 1, gwm_pkg::AnyChar, 0, 0, 0);
    push_beat(gwm_pkg::CMD_SET_HEADER, 1, 0, 0, 2, 1, 1);
    push_beat(gwm_pkg::CMD_PATH_CHAR, 0, 0, 16'h0061, 0, 0, 0);
    push_beat(gwm_pkg::CMD_PATH_CHAR, 0, 0, 16'h0062, 0, 0, 0);
    push_beat(gwm_pkg::CMD_END_PATH, 0, 0, 0, 0, 0, 0);
    push_beat(gwm_pkg::CMD_END_PATH, 0, 0, 0, 0, 0, 0);
    // char extremes, last position written but left outside the rule length
    push_beat(gwm_pkg::CMD_WRITE_CHAR, 7, 31, 16'hFFFF, 0, 0, 0);
    push_beat(gwm_pkg::CMD_WRITE_CHAR, 7, 0, 16'h0000, 0, 0, 0);
    push_beat(gwm_pkg::CMD_SET_HEADER, 7, 0, 0, 1, 0, 1);
    push_beat(gwm_pkg::CMD_PATH_CHAR, 0, 0, 16'h0000, 0, 0, 0);
    push_beat(gwm_pkg::CMD_END_PATH, 0, 0, 0, 0, 0, 0);
    // disable slot 0, re-arm slot 1 and rewrite one of its chars mid-path
    push_beat(gwm_pkg::CMD_SET_HEADER, 0, 0, 0, 0, 0, 0);
    push_beat(gwm_pkg::CMD_PATH_CHAR, 0, 0, 16'hFFFF, 0, 0, 0);
    push_beat(gwm_pkg::CMD_SET_HEADER, 1, 0, 0, 2, 1, 1);
    push_beat(gwm_pkg::CMD_PATH_CHAR, 0, 0, 16'h0061, 0, 0, 0);
    push_beat(gwm_pkg::CMD_WRITE_CHAR, 1, 1, 16'h007A, 0, 0, 0);
    push_beat(gwm_pkg::CMD_PATH_CHAR, 0, 0, 16'h007A, 0, 0, 0);
    push_beat(gwm_pkg::CMD_END_PATH, 0, 0, 0, 0, 0, 0);
    // empty exclude rule hits only the empty path
    push_beat(gwm_pkg::CMD_SET_HEADER, 7, 0, 0, 0, 1, 1);
    push_beat(gwm_pkg::CMD_END_PATH, 0, 0, 0, 0, 0, 0);
    wait_drained();

    // Random phases, alternating the ordering mode
    for (int ph = 0; ph < 4; ph++) begin
      set_mode(ph[0] == 1'b0 ? 1'b0 : 1'b1);
      snd_idle_pct  = snd_mix[ph];
      rcv_stall_pct = rcv_stall_mix[ph];
      hold_next = 1'b1;
      // oversized length saturates to the full pattern
      if (ph == 0) program_rule(3, 63);
      while (pend_beats.size() < 205) begin
        r = $urandom_range(0, 99);
        if (r < 18) begin
          program_rule($urandom_range(0, gwm_pkg::RuleSlots - 1),
                       ($urandom_range(0, 11) == 0) ? $urandom_range(20, 63)
                                                   : $urandom_range(0, 8));
        end else if (r < 82) begin
          send_path($urandom_range(0, gwm_pkg::RuleSlots - 1), $urandom_range(0, 3) == 0);
        end else begin
          repeat ($urandom_range(0, 6)) push_beat(gwm_pkg::CMD_PATH_CHAR, 0, 0,
                                                  pick_path_char(), 0, 0, 0);
          push_beat(gwm_pkg::CMD_END_PATH, 0, 0, 0, 0, 0, 0);
        end
      end
      wait_drained();
    end

    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    repeat (20) @(negedge clk_i);
    if (verdict_q.size() != 0) flag_error("verdicts still outstanding at end of run");

    $display("run covered %0d input beats and %0d judged paths (%0d include, %0d exclude hits)",
             in_taken, paths_judged, inc_seen, exc_seen);
    $display("ordering mode written %0d times under four stall mixes; %0d errors",
             mode_writes, err_count);
    if (err_count == 0) begin
      $display("glob_rule_path_matcher verification clean");
    end else begin
      $display("glob_rule_path_matcher verification failed");
    end
    $finish;
  end

endmodule
